// ----- src/dque_pkg.sv -----
// shared types and codes for the double-ended queue
// operation codes, status codes and field widths; no dependencies

package dque_pkg;

    // operation codes carried in the func field
    localparam logic [1:0] OP_PUSH_TOP      = 2'd0;
    localparam logic [1:0] OP_POP_TOP       = 2'd1;
    localparam logic [1:0] OP_INSERT_BOTTOM = 2'd2;
    localparam logic [1:0] OP_REMOVE_BOTTOM = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // fixed field widths of the stream payloads
    localparam int FUNC_W  = 2;
    localparam int VAL_W   = 32;
    localparam int OUT_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] status_t;

    // per-operation control passed from the index logic to the store and the middle stage
    typedef struct packed {
        status_t status;
        logic    wr_en;
    } dque_step_t;

endpackage

// ----- src/dque_ctrl.sv -----
// index and count logic of the double-ended queue
// depends on dque_pkg; drives the write and read addresses of dque_ring

module dque_ctrl #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32,
    parameter int IW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  dque_pkg::func_t       func,
    input  logic [WORD_WIDTH-1:0] value,
    input  logic [WORD_WIDTH-1:0] top_word,
    input  logic [WORD_WIDTH-1:0] bot_word,
    output dque_pkg::dque_step_t  step,
    output logic [IW-1:0]         wr_addr,
    output logic [WORD_WIDTH-1:0] wr_data,
    output logic [IW-1:0]         rd_top_addr,
    output logic [IW-1:0]         rd_bot_addr,
    output logic [WORD_WIDTH-1:0] taken,
    output logic [CW-1:0]         count_next
);
    import dque_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [IW-1:0] top_idx_reg, top_idx_next;
    logic [IW-1:0] bot_idx_reg, bot_idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          is_empty, is_full, many;
    logic [IW-1:0] top_up, top_down, bot_up, bot_down;

    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg >= FULL_CNT);
    assign many     = (cnt_reg > CW'(1));

    // ring wrap without a modulo
    assign top_up   = (top_idx_reg == LAST_IDX) ? '0 : top_idx_reg + IW'(1);
    assign top_down = (top_idx_reg == '0) ? LAST_IDX : top_idx_reg - IW'(1);
    assign bot_up   = (bot_idx_reg == LAST_IDX) ? '0 : bot_idx_reg + IW'(1);
    assign bot_down = (bot_idx_reg == '0) ? LAST_IDX : bot_idx_reg - IW'(1);

    always_comb begin
        top_idx_next = top_idx_reg;
        bot_idx_next = bot_idx_reg;
        cnt_next     = cnt_reg;
        wr_addr      = top_idx_reg;
        taken        = '0;
        step.status  = ST_OK;
        step.wr_en   = 1'b0;
        case (func)
            OP_PUSH_TOP: begin
                if (is_full) begin
                    step.status = ST_FULL;
                end else if (is_empty) begin
                    bot_idx_next = top_idx_reg;
                    wr_addr      = top_idx_reg;
                    step.wr_en   = 1'b1;
                    cnt_next     = CW'(1);
                end else begin
                    top_idx_next = top_up;
                    wr_addr      = top_up;
                    step.wr_en   = 1'b1;
                    cnt_next     = cnt_reg + CW'(1);
                end
            end
            OP_INSERT_BOTTOM: begin
                if (is_full) begin
                    step.status = ST_FULL;
                end else if (is_empty) begin
                    top_idx_next = bot_idx_reg;
                    wr_addr      = bot_idx_reg;
                    step.wr_en   = 1'b1;
                    cnt_next     = CW'(1);
                end else begin
                    bot_idx_next = bot_down;
                    wr_addr      = bot_down;
                    step.wr_en   = 1'b1;
                    cnt_next     = cnt_reg + CW'(1);
                end
            end
            OP_POP_TOP: begin
                if (is_empty) begin
                    step.status = ST_EMPTY;
                end else begin
                    taken    = top_word;
                    cnt_next = cnt_reg - CW'(1);
                    if (many) begin
                        top_idx_next = top_down;
                    end
                end
            end
            OP_REMOVE_BOTTOM: begin
                if (is_empty) begin
                    step.status = ST_EMPTY;
                end else begin
                    taken    = bot_word;
                    cnt_next = cnt_reg - CW'(1);
                    if (many) begin
                        bot_idx_next = bot_up;
                    end
                end
            end
            default: begin
                step.status = ST_OK;
            end
        endcase
        step.wr_en = step.wr_en & accept;
    end

    assign wr_data     = value;
    assign rd_top_addr = top_idx_next;
    assign rd_bot_addr = bot_idx_next;
    assign count_next  = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_idx_reg <= '0;
            bot_idx_reg <= '0;
            cnt_reg     <= '0;
        end else if (accept) begin
            top_idx_reg <= top_idx_next;
            bot_idx_reg <= bot_idx_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

// ----- src/dque_ring.sv -----
// ring store of the double-ended queue: one write port, two registered read ports
// depends on dque_pkg; read-during-write of the same slot is forwarded

module dque_ring #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32,
    parameter int IW         = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  dque_pkg::dque_step_t  step,
    input  logic                  rd_en,
    input  logic [IW-1:0]         wr_addr,
    input  logic [WORD_WIDTH-1:0] wr_data,
    input  logic [IW-1:0]         rd_top_addr,
    input  logic [IW-1:0]         rd_bot_addr,
    output logic [WORD_WIDTH-1:0] top_word,
    output logic [WORD_WIDTH-1:0] bot_word
);
    import dque_pkg::*;

    logic [WORD_WIDTH-1:0] ring_mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_top_reg, rd_bot_reg, wdata_reg;
    logic                  byp_top_reg, byp_bot_reg;

    always_ff @(posedge aclk) begin
        if (step.wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    // read data held until the next operation, so it always shows the current ends
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_top_reg  <= ring_mem[rd_top_addr];
            rd_bot_reg  <= ring_mem[rd_bot_addr];
            byp_top_reg <= step.wr_en && (rd_top_addr == wr_addr);
            byp_bot_reg <= step.wr_en && (rd_bot_addr == wr_addr);
            wdata_reg   <= wr_data;
        end
    end

    assign top_word = byp_top_reg ? wdata_reg : rd_top_reg;
    assign bot_word = byp_bot_reg ? wdata_reg : rd_bot_reg;

endmodule

// ----- src/double_ended_queue.sv -----
// Double-ended queue of DEPTH words held in a ring store. Each input transfer carries an
// operation (push top, pop top, insert bottom, remove bottom) and a word; each one gives
// exactly one result transfer with the removed word, a status (ok, empty, full), the count
// after the operation and the words then at the top and the bottom (zero when empty).
// One operation is taken every clock cycle while results are being taken. On acceptance the
// indices are updated, the store is written and both ends are read into the registered read
// ports; the result then moves from the middle stage into the output register.
// The store needs no clearing after reset; the queue is ready as soon as reset is released.
// depends on dque_pkg, dque_ctrl, dque_ring

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // operation channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dque_pkg::IN_TDATA_W-1:0]     s_tdata,  // func[1:0], value[33:2], zero
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dque_pkg::OUT_TDATA_W-1:0]    m_tdata   // out_value[31:0], status[33:32],
                                                          // count[38:34], top_value[70:39],
                                                          // bottom_value[102:71], zero
);
    import dque_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // input field unpacking
    func_t                 in_func;
    logic [WORD_WIDTH-1:0] in_value;
    logic                  accept;

    assign in_func  = s_tdata[FUNC_W-1:0];
    assign in_value = WORD_WIDTH'(s_tdata[FUNC_W +: VAL_W]);
    assign accept   = s_tvalid && s_tready;

    // control and store
    dque_step_t            step;
    logic [IW-1:0]         wr_addr, rd_top_addr, rd_bot_addr;
    logic [WORD_WIDTH-1:0] wr_data, taken, top_word, bot_word;
    logic [CW-1:0]         count_next;

    dque_ctrl #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .func        (in_func),
        .value       (in_value),
        .top_word    (top_word),
        .bot_word    (bot_word),
        .step        (step),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_top_addr (rd_top_addr),
        .rd_bot_addr (rd_bot_addr),
        .taken       (taken),
        .count_next  (count_next)
    );

    dque_ring #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH),
        .IW         (IW)
    ) u_ring (
        .aclk        (aclk),
        .step        (step),
        .rd_en       (accept),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_top_addr (rd_top_addr),
        .rd_bot_addr (rd_bot_addr),
        .top_word    (top_word),
        .bot_word    (bot_word)
    );

    // middle stage: removed word, status and count wait here while the store reads the ends
    logic                  p_valid_reg, p_valid_next;
    logic [WORD_WIDTH-1:0] p_taken_reg;
    status_t               p_status_reg;
    logic [CW-1:0]         p_count_reg;
    logic                  p_move;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]      m_out_value_reg, m_top_reg, m_bottom_reg;
    status_t               m_status_reg;
    logic [CNT_W-1:0]      m_count_reg;
    logic                  p_nonempty;

    assign p_move     = p_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !p_valid_reg || p_move;
    assign p_nonempty = (p_count_reg != '0);

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (p_move) begin
            p_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p_move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_taken_reg  <= taken;
            p_status_reg <= step.status;
            p_count_reg  <= count_next;
        end
    end

    // ends read as zero when the queue is empty
    always_ff @(posedge aclk) begin
        if (p_move) begin
            m_out_value_reg <= OUT_W'(p_taken_reg);
            m_status_reg    <= p_status_reg;
            m_count_reg     <= CNT_W'(p_count_reg);
            m_top_reg       <= p_nonempty ? OUT_W'(top_word) : '0;
            m_bottom_reg    <= p_nonempty ? OUT_W'(bot_word) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_bottom_reg, m_top_reg, m_count_reg, m_status_reg,
                       m_out_value_reg};

    // a full report always comes with the queue holding all of its slots
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_FULL) |-> (m_count_reg == CNT_W'(DEPTH)))
        else $error("full status with a count below the depth");

    // an empty queue shows zero at both ends
    a_empty_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_count_reg == '0) && (DEPTH < 32)
            |-> (m_top_reg == '0) && (m_bottom_reg == '0))
        else $error("nonzero end word with an empty queue");

    // a refused operation takes nothing out
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != ST_OK) |-> (m_out_value_reg == '0))
        else $error("word taken on an empty or full report");

    // input only stalls when both stages hold results that cannot move
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> p_valid_reg && m_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    // an accepted operation enters the middle stage in the next cycle when the output register is free
    a_pass_on: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !p_valid_reg && (!m_valid_reg || m_tready) |=> p_valid_reg)
        else $error("accepted operation lost from the middle stage");

endmodule
